[rtl/fgcl_pkg.sv]
package fgcl_pkg;

  // Store sizes in bytes.
  localparam int unsigned PATCH_BYTES = 256;
  localparam int unsigned MAIN_BYTES  = 1024;

  // Walk and read addresses are wide enough for a run skip past the end of either store.
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned OFFS_W   = 10;
  localparam int unsigned PATCH_AW = $clog2(PATCH_BYTES);
  localparam int unsigned MAIN_AW  = $clog2(MAIN_BYTES);

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Font codes.
  localparam logic FONT_PATCH = 1'b0;
  localparam logic FONT_MAIN  = 1'b1;

  // Advance width reported for a missing glyph.
  localparam logic [3:0] MISS_ADVANCE = 4'd3;

  // Address unit operations.
  typedef enum logic [1:0] {
    ADDR_OP_HOLD,
    ADDR_OP_NEXT,
    ADDR_OP_SKIP,
    ADDR_OP_COL
  } addr_op_e;

  typedef struct packed {
    logic              font;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic              font;
    logic [OFFS_W-1:0] offset;
    logic [7:0]        value;
  } wr_req_t;

endpackage

[rtl/font_glyph_column_lookup.sv]
// Font glyph column lookup. A write command (opcode 0) stores one byte into the patch
// font or the main font image and finishes in the cycle it is accepted, with no result.
// A lookup command (opcode 1) walks the patch font's run headers and then the main
// font's, and returns one result beat: found flag, font used, advance width and the
// requested column byte. Each header examined costs a flags read and a start character
// read; a lookup also reads each chain terminator it meets, and the column byte when
// the column lies inside the glyph. A hit in the patch font reads no terminator, a hit
// in the main font reads one, and a miss reads two but no column. busy_o stays high
// while these reads run, and the result beat follows in the next cycle. The single
// read port of the font stores is why every header byte and the column byte are
// fetched one at a time.
// busy_o is high while a lookup runs. The result beat is shown for exactly one cycle
// on result_valid_o and the receiver cannot stall it; busy_o is already low in that
// cycle, so the next command may be issued alongside the result beat. The main font
// must be loaded before any lookup reads it; the patch font reads as zero after reset.
module font_glyph_column_lookup import fgcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       opcode_i,
  input  logic       font_select_i,
  input  logic [9:0] offset_i,
  input  logic [7:0] write_value_i,
  input  logic [7:0] character_i,
  input  logic [7:0] column_i,
  output logic       result_valid_o,
  output logic       found_o,
  output logic       font_used_o,
  output logic [3:0] advance_width_o,
  output logic [7:0] column_bits_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLAGS = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_COL   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              font_q, font_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [7:0]        flags_q, flags_d;
  logic [7:0]        char_q, col_q;

  logic       res_valid_q, res_valid_d;
  logic       res_found_q, res_found_d;
  logic       res_font_q, res_font_d;
  logic [3:0] res_adv_q, res_adv_d;
  logic [7:0] res_bits_q, res_bits_d;

  logic              accept;
  wr_req_t           wr_req;
  rd_req_t           rd_req;
  logic [7:0]        rdata;
  addr_op_e          au_op;
  logic [3:0]        au_factor;
  logic [ADDR_W-1:0] au_addr;

  logic [3:0] run_count;
  logic [3:0] run_width;
  logic [7:0] char_diff;
  logic       run_hit;
  logic       col_in_glyph;

  assign accept = start_i && !busy_o;

  // Writes go straight to the stores at the accepting edge.
  assign wr_req.en     = accept && (opcode_i == OP_WRITE);
  assign wr_req.font   = font_select_i;
  assign wr_req.offset = offset_i;
  assign wr_req.value  = write_value_i;

  fgcl_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  // Header decode; in the start state the store returns the run's start character.
  assign run_count    = flags_q[7:4];
  assign run_width    = {1'b0, flags_q[2:0]} + 4'd1;
  assign char_diff    = char_q - rdata;
  assign run_hit      = (char_q >= rdata) && (char_diff < {4'd0, run_count});
  assign col_in_glyph = col_q < {4'd0, run_width};

  // One address unit serves the start-byte fetch, the run skip and the column address.
  assign au_factor = run_hit ? char_diff[3:0] : run_count;

  fgcl_addr_unit u_addr (
    .op_i     (au_op),
    .base_i   (ptr_q),
    .factor_i (au_factor),
    .wm1_i    (flags_q[2:0]),
    .col_i    (col_q[2:0]),
    .addr_o   (au_addr)
  );

  always_comb begin
    state_d     = state_q;
    font_d      = font_q;
    ptr_d       = ptr_q;
    flags_d     = flags_q;
    au_op       = ADDR_OP_HOLD;
    rd_req.font = font_q;
    rd_req.addr = au_addr;
    res_valid_d = 1'b0;
    res_found_d = res_found_q;
    res_font_d  = res_font_q;
    res_adv_d   = res_adv_q;
    res_bits_d  = res_bits_q;

    case (state_q)
      ST_IDLE: begin
        // Begin with the first header of the patch font.
        rd_req.font = FONT_PATCH;
        rd_req.addr = '0;
        if (accept && (opcode_i == OP_LOOKUP)) begin
          state_d = ST_FLAGS;
          font_d  = FONT_PATCH;
          ptr_d   = '0;
        end
      end
      ST_FLAGS: begin
        if (rdata == 8'd0) begin
          if (font_q == FONT_PATCH) begin
            // Patch chain exhausted; restart on the main font.
            font_d      = FONT_MAIN;
            ptr_d       = '0;
            rd_req.font = FONT_MAIN;
            rd_req.addr = '0;
          end else begin
            // Neither font holds the character.
            state_d     = ST_IDLE;
            res_valid_d = 1'b1;
            res_found_d = 1'b0;
            res_font_d  = FONT_PATCH;
            res_adv_d   = MISS_ADVANCE;
            res_bits_d  = 8'd0;
          end
        end else begin
          flags_d = rdata;
          au_op   = ADDR_OP_NEXT;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!run_hit) begin
          au_op   = ADDR_OP_SKIP;
          ptr_d   = au_addr;
          state_d = ST_FLAGS;
        end else if (col_in_glyph) begin
          au_op   = ADDR_OP_COL;
          state_d = ST_COL;
        end else begin
          // Padding column: the glyph is found but the column is blank.
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_found_d = 1'b1;
          res_font_d  = font_q;
          res_adv_d   = run_width + 4'd1;
          res_bits_d  = 8'd0;
        end
      end
      ST_COL: begin
        state_d     = ST_IDLE;
        res_valid_d = 1'b1;
        res_found_d = 1'b1;
        res_font_d  = font_q;
        res_adv_d   = run_width + 4'd1;
        res_bits_d  = rdata;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      font_q      <= FONT_PATCH;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      font_q      <= font_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q    <= flags_d;
    res_found_q <= res_found_d;
    res_font_q <= res_font_d;
    res_adv_q  <= res_adv_d;
    res_bits_q <= res_bits_d;
    if (accept) begin
      char_q <= character_i;
      col_q  <= column_i;
    end
  end

  assign busy_o          = state_q != ST_IDLE;
  assign result_valid_o  = res_valid_q;
  assign found_o         = res_found_q;
  assign font_used_o     = res_font_q;
  assign advance_width_o = res_adv_q;
  assign column_bits_o   = res_bits_q;

  // A lookup always reads more than one byte before its result, so result beats never touch.
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result beats");

  // A missing glyph reports the fixed miss answer.
  a_miss_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |->
      (advance_width_o == MISS_ADVANCE && column_bits_o == 8'd0 && !font_used_o))
    else $error("malformed miss result");

  // A write command never produces a result beat.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_WRITE) |=> !result_valid_o)
    else $error("result after a write command");

  // The sequencer is back in idle when its result beat appears.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("busy during a result beat");

endmodule

[rtl/fgcl_store.sv]
module fgcl_store import fgcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_req_t    wr_i,
  input  rd_req_t    rd_i,
  output logic [7:0] rdata_o
);

  logic [7:0]             patch_mem [PATCH_BYTES];
  logic [7:0]             main_mem  [MAIN_BYTES];
  logic [PATCH_BYTES-1:0] patch_valid_q;

  logic       patch_wr, main_wr;
  logic       patch_rd_ok, main_rd_ok;
  logic [7:0] patch_data_q, main_data_q;
  logic       patch_ok_q, main_ok_q, font_q;

  assign patch_wr = wr_i.en && (wr_i.font == FONT_PATCH) &&
                    ({1'b0, wr_i.offset} < ADDR_W'(PATCH_BYTES));
  assign main_wr  = wr_i.en && (wr_i.font == FONT_MAIN) &&
                    ({1'b0, wr_i.offset} < ADDR_W'(MAIN_BYTES));

  assign patch_rd_ok = rd_i.addr < ADDR_W'(PATCH_BYTES);
  assign main_rd_ok  = rd_i.addr < ADDR_W'(MAIN_BYTES);

  // Patch entries that were never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_valid_q <= '0;
    end else if (patch_wr) begin
      patch_valid_q[wr_i.offset[PATCH_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (patch_wr) begin
      patch_mem[wr_i.offset[PATCH_AW-1:0]] <= wr_i.value;
    end
    if (main_wr) begin
      main_mem[wr_i.offset[MAIN_AW-1:0]] <= wr_i.value;
    end
    patch_data_q <= patch_mem[rd_i.addr[PATCH_AW-1:0]];
    main_data_q  <= main_mem[rd_i.addr[MAIN_AW-1:0]];
    patch_ok_q   <= patch_rd_ok && patch_valid_q[rd_i.addr[PATCH_AW-1:0]];
    main_ok_q    <= main_rd_ok;
    font_q       <= rd_i.font;
  end

  always_comb begin
    rdata_o = 8'd0;
    if (font_q == FONT_PATCH) begin
      if (patch_ok_q) rdata_o = patch_data_q;
    end else begin
      if (main_ok_q) rdata_o = main_data_q;
    end
  end

endmodule

[rtl/fgcl_addr_unit.sv]
module fgcl_addr_unit import fgcl_pkg::*; (
  input  addr_op_e          op_i,
  input  logic [ADDR_W-1:0] base_i,
  input  logic [3:0]        factor_i,
  input  logic [2:0]        wm1_i,
  input  logic [2:0]        col_i,
  output logic [ADDR_W-1:0] addr_o
);

  logic [3:0] width;
  logic [7:0] prod;

  assign width = {1'b0, wm1_i} + 4'd1;
  assign prod  = {4'd0, factor_i} * {4'd0, width};

  always_comb begin
    case (op_i)
      ADDR_OP_NEXT: addr_o = base_i + ADDR_W'(1);
      ADDR_OP_SKIP: addr_o = base_i + ADDR_W'(2) + ADDR_W'(prod);
      ADDR_OP_COL:  addr_o = base_i + ADDR_W'(2) + ADDR_W'(prod) + ADDR_W'(col_i);
      default:      addr_o = base_i;
    endcase
  end

endmodule
